[rtl/core/mtk_pkg.sv]
package mtk_pkg;

   // time base and register file geometry
   localparam int TIME_WIDTH_DEF = 32;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [CSR_DATA_W-1:0] TIMEOUT_RESET = 32'd1000;
   localparam logic [CSR_DATA_W-1:0] HOLD_RESET    = 32'd500;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD    = 1'd1;

   // item kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // key codes
   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_HASH       = 4'd10;

   // entry modes
   localparam logic [1:0] ENTRY_ABC_INIT = 2'd0;
   localparam logic [1:0] ENTRY_LOWER    = 2'd1;
   localparam logic [1:0] ENTRY_UPPER    = 2'd2;
   localparam logic [1:0] ENTRY_NUMERIC  = 2'd3;

   // mode indicator codes
   localparam logic [2:0] IND_NONE     = 3'd0;
   localparam logic [2:0] IND_ABC_INIT = 3'd1;
   localparam logic [2:0] IND_LOWER    = 3'd2;
   localparam logic [2:0] IND_UPPER    = 3'd3;
   localparam logic [2:0] IND_NUMERIC  = 3'd4;

   localparam logic [7:0] CASE_OFFSET = 8'd32;

   typedef struct packed {
      logic       mode;
      logic [3:0] key;
      logic       key_down;
      logic       field_active;
      logic       numeric_edit;
      logic       caret_at_start;
      logic       prev_char_space;
   } req_item_type;

   typedef struct packed {
      logic       handled;
      logic       do_backspace;
      logic       do_insert;
      logic [7:0] char_code;
      logic [2:0] mode_indicator;
      logic       pending;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] timeout_ticks;
      logic [CSR_DATA_W-1:0] hold_ticks;
   } cfg_type;

   // number of characters in each digit key's cycle
   function automatic logic [4:0] cycle_len(input logic [3:0] key);
      logic [4:0] len;
      case (key)
         4'd0:    len = 5'd2;
         4'd1:    len = 5'd17;
         4'd7:    len = 5'd5;
         4'd9:    len = 5'd5;
         default: len = 5'd4;
      endcase
      return len;
   endfunction

   // character of a digit key's cycle at a given position
   function automatic logic [7:0] cycle_char(input logic [3:0] key, input logic [4:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (key)
         4'd0: begin
            case (idx)
               5'd0:    c = " ";
               default: c = "0";
            endcase
         end
         4'd1: begin
            case (idx)
               5'd0:    c = ".";
               5'd1:    c = ",";
               5'd2:    c = "?";
               5'd3:    c = "!";
               5'd4:    c = "1";
               5'd5:    c = "@";
               5'd6:    c = "\"";
               5'd7:    c = "-";
               5'd8:    c = "_";
               5'd9:    c = "(";
               5'd10:   c = ")";
               5'd11:   c = ":";
               5'd12:   c = ";";
               5'd13:   c = "&";
               5'd14:   c = "/";
               5'd15:   c = "%";
               default: c = "*";
            endcase
         end
         4'd2: begin
            case (idx)
               5'd0: c = "a";  5'd1: c = "b";  5'd2: c = "c";
               default: c = "2";
            endcase
         end
         4'd3: begin
            case (idx)
               5'd0: c = "d";  5'd1: c = "e";  5'd2: c = "f";
               default: c = "3";
            endcase
         end
         4'd4: begin
            case (idx)
               5'd0: c = "g";  5'd1: c = "h";  5'd2: c = "i";
               default: c = "4";
            endcase
         end
         4'd5: begin
            case (idx)
               5'd0: c = "j";  5'd1: c = "k";  5'd2: c = "l";
               default: c = "5";
            endcase
         end
         4'd6: begin
            case (idx)
               5'd0: c = "m";  5'd1: c = "n";  5'd2: c = "o";
               default: c = "6";
            endcase
         end
         4'd7: begin
            case (idx)
               5'd0: c = "p";  5'd1: c = "q";  5'd2: c = "r";  5'd3: c = "s";
               default: c = "7";
            endcase
         end
         4'd8: begin
            case (idx)
               5'd0: c = "t";  5'd1: c = "u";  5'd2: c = "v";
               default: c = "8";
            endcase
         end
         4'd9: begin
            case (idx)
               5'd0: c = "w";  5'd1: c = "x";  5'd2: c = "y";  5'd3: c = "z";
               default: c = "9";
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // letter case per entry mode
   function automatic logic [7:0] apply_case(input logic [7:0] c, input logic [1:0] entry,
                                             input logic word_start);
      logic [7:0] r;
      r = c;
      if (c inside {["a":"z"]}) begin
         if (entry == ENTRY_UPPER || (entry == ENTRY_ABC_INIT && word_start)) begin
            r = c - CASE_OFFSET;
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/mtk_if.sv]
interface mtk_req_if #(
   parameter int TIME_WIDTH = mtk_pkg::TIME_WIDTH_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [3:0]            key;
   logic                  key_down;
   logic [TIME_WIDTH-1:0] now;
   logic                  field_active;
   logic                  numeric_edit;
   logic                  caret_at_start;
   logic                  prev_char_space;

   modport source (
      output valid, mode, key, key_down, now, field_active, numeric_edit,
             caret_at_start, prev_char_space,
      input  ready
   );
   modport sink (
      input  valid, mode, key, key_down, now, field_active, numeric_edit,
             caret_at_start, prev_char_space,
      output ready
   );
endinterface

interface mtk_rsp_if;
   logic       valid;
   logic       ready;
   logic       handled;
   logic       do_backspace;
   logic       do_insert;
   logic [7:0] char_code;
   logic [2:0] mode_indicator;
   logic       pending;

   modport source (
      output valid, handled, do_backspace, do_insert, char_code, mode_indicator, pending,
      input  ready
   );
   modport sink (
      input  valid, handled, do_backspace, do_insert, char_code, mode_indicator, pending,
      output ready
   );
endinterface

[rtl/core/multi_tap_keypad_text_entry.sv]
// Multi-tap keypad text entry engine. Each request transaction is either a key event or a
// time tick, both stamped with the current tick count; every request gives exactly one
// response transaction that says whether the key was consumed, whether to backspace over
// the previous candidate, which character to insert, the mode to show and whether a letter
// is still pending. Timeout and hash hold length are set through the csr write port, which
// may only be written while no transaction is in flight. One request is taken every cycle
// while the response side keeps ready high; a request accepted into the input register is
// decoded, compared and looked up in a single pass out of that register and lands in the
// response register, from which its response is offered. The pipeline only stalls when the
// response side holds ready low.
module multi_tap_keypad_text_entry #(
   parameter int TIME_WIDTH = mtk_pkg::TIME_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mtk_req_if.sink                         req_bus,
   mtk_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [mtk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mtk_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // input stage
   logic                  in_valid_ff, in_valid_in;
   mtk_pkg::req_item_type item_ff, item_in;
   logic [TIME_WIDTH-1:0] now_ff;

   // response stage
   logic                  rsp_valid_ff, rsp_valid_in;
   mtk_pkg::rsp_item_type rsp_ff, result;

   mtk_pkg::cfg_type      cfg;
   logic                  out_ready;   // response register can take a new result
   logic                  advance;     // input stage moves into the response register
   logic                  req_take;

   assign out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign advance   = in_valid_ff && out_ready;
   assign req_take  = req_bus.valid && req_bus.ready;

   // input stage frees up in the same cycle it hands over, so transactions stream
   assign req_bus.ready = !in_valid_ff || out_ready;

   mtk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state is committed only when the transaction moves on
   mtk_engine #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (item_ff),
      .item_now (now_ff),
      .cfg      (cfg),
      .result   (result)
   );

   always_comb begin
      item_in.mode            = req_bus.mode;
      item_in.key             = req_bus.key;
      item_in.key_down        = req_bus.key_down;
      item_in.field_active    = req_bus.field_active;
      item_in.numeric_edit    = req_bus.numeric_edit;
      item_in.caret_at_start  = req_bus.caret_at_start;
      item_in.prev_char_space = req_bus.prev_char_space;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
         now_ff  <= req_bus.now;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.handled        = rsp_ff.handled;
   assign rsp_bus.do_backspace   = rsp_ff.do_backspace;
   assign rsp_bus.do_insert      = rsp_ff.do_insert;
   assign rsp_bus.char_code      = rsp_ff.char_code;
   assign rsp_bus.mode_indicator = rsp_ff.mode_indicator;
   assign rsp_bus.pending        = rsp_ff.pending;

   // a backspace always comes with the replacement character
   a_bs_with_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.do_backspace |-> rsp_ff.do_insert && rsp_ff.handled)
      else $error("backspace without insert");

   // no character code unless an insert is asked for
   a_code_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.do_insert |-> rsp_ff.char_code == 8'h00)
      else $error("char code without insert");

   // without a focused field nothing is consumed or shown as pending
   a_no_field_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.mode_indicator == mtk_pkg::IND_NONE
      |-> !rsp_ff.handled && !rsp_ff.pending && !rsp_ff.do_insert)
      else $error("activity without a field");

   // a held input transaction must stall the request side
   a_input_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |-> !req_bus.ready)
      else $error("request accepted over a stalled transaction");

endmodule

[rtl/core/mtk_csr.sv]
module mtk_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mtk_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mtk_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output mtk_pkg::cfg_type                     cfg
);

   logic [mtk_pkg::CSR_DATA_W-1:0] timeout_ff;
   logic [mtk_pkg::CSR_DATA_W-1:0] hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= mtk_pkg::TIMEOUT_RESET;
         hold_ff    <= mtk_pkg::HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mtk_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            mtk_pkg::CSR_HOLD:    hold_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.timeout_ticks = timeout_ff;
   assign cfg.hold_ticks    = hold_ff;

endmodule

[rtl/core/mtk_engine.sv]
module mtk_engine #(
   parameter int TIME_WIDTH = mtk_pkg::TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mtk_pkg::req_item_type item,
   input  logic [TIME_WIDTH-1:0] item_now,
   input  mtk_pkg::cfg_type      cfg,
   output mtk_pkg::rsp_item_type result
);

   localparam int CMP_W = (TIME_WIDTH > mtk_pkg::CSR_DATA_W) ? TIME_WIDTH
                                                             : mtk_pkg::CSR_DATA_W;

   logic [1:0]            entry_mode_ff, entry_mode_in;
   logic                  pending_valid_ff, pending_valid_in;
   logic [3:0]            pending_key_ff, pending_key_in;
   logic [4:0]            tap_index_ff, tap_index_in;
   logic [TIME_WIDTH-1:0] last_tap_ff, last_tap_in;
   logic [TIME_WIDTH-1:0] hash_down_ff, hash_down_in;

   logic [TIME_WIDTH-1:0] tap_elapsed, hash_elapsed;
   logic                  tap_expired, hash_held;
   logic                  numeric_sel, key_digit, retap;
   logic [4:0]            len, tap_next;

   always_comb begin
      tap_elapsed  = item_now - last_tap_ff;
      hash_elapsed = item_now - hash_down_ff;
      tap_expired  = CMP_W'(tap_elapsed) >= CMP_W'(cfg.timeout_ticks);
      hash_held    = CMP_W'(hash_elapsed) >= CMP_W'(cfg.hold_ticks);
      numeric_sel  = (entry_mode_ff == mtk_pkg::ENTRY_NUMERIC) || item.numeric_edit;
      key_digit    = item.key <= mtk_pkg::KEY_LAST_DIGIT;
      len          = mtk_pkg::cycle_len(item.key);
      tap_next     = tap_index_ff + 5'd1;
      retap        = pending_valid_ff && (pending_key_ff == item.key) && !tap_expired;

      entry_mode_in    = entry_mode_ff;
      pending_valid_in = pending_valid_ff;
      pending_key_in   = pending_key_ff;
      tap_index_in     = tap_index_ff;
      last_tap_in      = last_tap_ff;
      hash_down_in     = hash_down_ff;
      result           = '0;

      if (item.mode == mtk_pkg::KIND_TICK) begin
         if (pending_valid_ff && tap_expired) begin
            pending_valid_in = 1'b0;
         end
      end else if (item.field_active) begin
         if (item.key == mtk_pkg::KEY_HASH) begin
            result.handled = 1'b1;
            if (item.key_down) begin
               hash_down_in = item_now;
            end else begin
               if (hash_held) begin
                  entry_mode_in = mtk_pkg::ENTRY_NUMERIC;
               end else if (entry_mode_ff == mtk_pkg::ENTRY_UPPER ||
                            entry_mode_ff == mtk_pkg::ENTRY_NUMERIC) begin
                  entry_mode_in = mtk_pkg::ENTRY_ABC_INIT;
               end else begin
                  entry_mode_in = entry_mode_ff + 2'd1;
               end
               pending_valid_in = 1'b0;
               tap_index_in     = '0;
            end
         end else if (!item.key_down) begin
            result.handled = 1'b1;
         end else if (numeric_sel) begin
            if (key_digit) begin
               pending_valid_in = 1'b0;
               tap_index_in     = '0;
               result.handled   = 1'b1;
               result.do_insert = 1'b1;
               result.char_code = "0" + 8'(item.key);
            end
         end else if (key_digit) begin
            if (retap) begin
               result.do_backspace = 1'b1;
               tap_index_in = (tap_next >= len) ? 5'd0 : tap_next;
            end else begin
               tap_index_in = '0;
            end
            result.char_code = mtk_pkg::apply_case(
               mtk_pkg::cycle_char(item.key, tap_index_in), entry_mode_ff,
               item.caret_at_start || item.prev_char_space);
            result.do_insert = 1'b1;
            result.handled   = 1'b1;
            pending_valid_in = 1'b1;
            pending_key_in   = item.key;
            last_tap_in      = item_now;
         end
      end

      if (!item.field_active) begin
         result.mode_indicator = mtk_pkg::IND_NONE;
      end else if (entry_mode_in == mtk_pkg::ENTRY_NUMERIC || item.numeric_edit) begin
         result.mode_indicator = mtk_pkg::IND_NUMERIC;
      end else begin
         case (entry_mode_in)
            mtk_pkg::ENTRY_ABC_INIT: result.mode_indicator = mtk_pkg::IND_ABC_INIT;
            mtk_pkg::ENTRY_LOWER:    result.mode_indicator = mtk_pkg::IND_LOWER;
            default:                 result.mode_indicator = mtk_pkg::IND_UPPER;
         endcase
      end
      result.pending = pending_valid_in && item.field_active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_mode_ff    <= mtk_pkg::ENTRY_ABC_INIT;
         pending_valid_ff <= 1'b0;
         pending_key_ff   <= '0;
         tap_index_ff     <= '0;
         last_tap_ff      <= '0;
         hash_down_ff     <= '0;
      end else if (step) begin
         entry_mode_ff    <= entry_mode_in;
         pending_valid_ff <= pending_valid_in;
         pending_key_ff   <= pending_key_in;
         tap_index_ff     <= tap_index_in;
         last_tap_ff      <= last_tap_in;
         hash_down_ff     <= hash_down_in;
      end
   end

endmodule
